// ----- rtl/pdc_pkg.sv -----
// shared types and constants for the packet deframer and checker
// no dependencies; imported by every module of the block
package pdc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 6;
  localparam int unsigned EventW   = 2;
  localparam int unsigned ErrW     = 3;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;
  localparam int unsigned OutDataW = 40;

  // hard ceiling on payload length, combined with the max_length register
  localparam logic [LenW-1:0] MaxPayload = 6'd57;

  // register indexes (byte address / 4)
  localparam logic [1:0] RegHeader = 2'd0;
  localparam logic [1:0] RegFooter = 2'd1;
  localparam logic [1:0] RegMaxLen = 2'd2;

  localparam logic [ByteW-1:0]  HeaderRst = 8'hAA;
  localparam logic [ByteW-1:0]  FooterRst = 8'h55;
  localparam logic [LenW-1:0]   MaxLenRst = 6'd57;

  // result kinds
  localparam logic [EventW-1:0] EvNone = 2'd0;
  localparam logic [EventW-1:0] EvData = 2'd1;
  localparam logic [EventW-1:0] EvGood = 2'd2;
  localparam logic [EventW-1:0] EvBad  = 2'd3;

  // error codes
  localparam logic [ErrW-1:0] ErrNone   = 3'd0;
  localparam logic [ErrW-1:0] ErrLength = 3'd1;
  localparam logic [ErrW-1:0] ErrType   = 3'd2;
  localparam logic [ErrW-1:0] ErrDest   = 3'd3;
  localparam logic [ErrW-1:0] ErrFooter = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0] header_byte;
    logic [ByteW-1:0] footer_byte;
    logic [LenW-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [ErrW-1:0]   error_code;
    logic [LenW-1:0]   length;
    logic [ByteW-1:0]  packet_type;
    logic [ByteW-1:0]  dest;
    logic [ByteW-1:0]  payload_byte;
  } result_t;

endpackage

// ----- rtl/pdc_cfg_regs.sv -----
// apb-style configuration registers: header byte, footer byte, max length
// depends on pdc_pkg
module pdc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pdc_pkg::AddrW-1:0]  paddr,
  input  logic [pdc_pkg::DataW-1:0]  pwdata,
  output logic [pdc_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output pdc_pkg::cfg_t              cfg_o
);
  import pdc_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte <= HeaderRst;
      cfg_q.footer_byte <= FooterRst;
      cfg_q.max_length  <= MaxLenRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegHeader: cfg_q.header_byte <= pwdata[ByteW-1:0];
        RegFooter: cfg_q.footer_byte <= pwdata[ByteW-1:0];
        RegMaxLen: cfg_q.max_length  <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegHeader: prdata = {{(DataW-ByteW){1'b0}}, cfg_q.header_byte};
      RegFooter: prdata = {{(DataW-ByteW){1'b0}}, cfg_q.footer_byte};
      RegMaxLen: prdata = {{(DataW-LenW){1'b0}}, cfg_q.max_length};
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/pdc_parser.sv -----
// frame state machine, field capture, checks and registered result stage
// depends on pdc_pkg
module pdc_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pdc_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pdc_pkg::ByteW-1:0]  in_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pdc_pkg::result_t           out_res_o
);
  import pdc_pkg::*;

  typedef enum logic [2:0] {
    PhHunt, PhDest, PhType, PhLen, PhPayload, PhNType, PhNDest, PhFooter
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] dest_q, dest_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [ErrW-1:0]  ferr_q, ferr_d;
  logic             out_valid_q;
  result_t          res_q, res_d;

  logic             accept;
  logic [LenW-1:0]  limit;
  logic             too_long;
  logic [LenW-1:0]  cnt_inc;

  // result stage frees up whenever its item is taken
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign limit    = (cfg_i.max_length > MaxPayload) ? MaxPayload : cfg_i.max_length;
  assign too_long = in_byte_i > {{(ByteW-LenW){1'b0}}, limit};
  assign cnt_inc  = cnt_q + LenW'(1);

  always_comb begin
    phase_d = phase_q;
    dest_d  = dest_q;
    type_d  = type_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    ferr_d  = ferr_q;
    res_d   = '0;
    res_d.event_res  = EvNone;
    res_d.error_code = ErrNone;

    case (phase_q)
      PhHunt: begin
        if (in_byte_i == cfg_i.header_byte) begin
          ferr_d  = ErrNone;
          phase_d = PhDest;
        end
      end
      PhDest: begin
        dest_d  = in_byte_i;
        phase_d = PhType;
      end
      PhType: begin
        type_d  = in_byte_i;
        phase_d = PhLen;
      end
      PhLen: begin
        if (too_long) begin
          len_d            = '0;
          res_d.event_res  = EvBad;
          res_d.error_code = ErrLength;
          phase_d          = PhHunt;
        end else begin
          len_d   = in_byte_i[LenW-1:0];
          cnt_d   = '0;
          phase_d = (in_byte_i[LenW-1:0] == '0) ? PhNType : PhPayload;
        end
      end
      PhPayload: begin
        res_d.event_res    = EvData;
        res_d.payload_byte = in_byte_i;
        cnt_d              = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = PhNType;
        end
      end
      PhNType: begin
        if (((~in_byte_i) != type_q) && (ferr_q == ErrNone)) begin
          ferr_d = ErrType;
        end
        phase_d = PhNDest;
      end
      PhNDest: begin
        if (((~in_byte_i) != dest_q) && (ferr_q == ErrNone)) begin
          ferr_d = ErrDest;
        end
        phase_d = PhFooter;
      end
      PhFooter: begin
        if ((in_byte_i != cfg_i.footer_byte) && (ferr_q == ErrNone)) begin
          ferr_d = ErrFooter;
        end
        if (ferr_d == ErrNone) begin
          res_d.event_res = EvGood;
        end else begin
          res_d.event_res  = EvBad;
          res_d.error_code = ferr_d;
        end
        phase_d = PhHunt;
      end
      default: phase_d = PhHunt;
    endcase

    res_d.dest        = dest_d;
    res_d.packet_type = type_d;
    res_d.length      = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      dest_q      <= '0;
      type_q      <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      ferr_q      <= ErrNone;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        dest_q  <= dest_d;
        type_q  <= type_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        ferr_q  <= ferr_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  a_data_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.event_res == EvData) |-> res_q.error_code == ErrNone)
    else $error("payload item carries an error code");

  a_bad_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.event_res == EvBad) |-> res_q.error_code != ErrNone)
    else $error("bad verdict without an error code");

  a_long_rehunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PhLen && too_long) |=> phase_q == PhHunt && len_q == '0)
    else $error("oversized length did not return to hunting");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> cnt_q < len_q)
    else $error("payload count ran past the length");

endmodule

// ----- rtl/packet_deframer_checker.sv -----
// top level of the packet deframer and checker
// depends on pdc_pkg, pdc_cfg_regs and pdc_parser
//
// usage
//   s_axis carries one received byte per item in tdata[7:0]. m_axis gives
//   exactly one result item per input byte: tuser holds the event kind
//   (nothing, payload byte, packet good, packet bad), tdata the payload
//   byte, the held destination, type and length, and the error code.
//   the apb port sets the header byte, footer byte and maximum length;
//   write it only while the stream is idle.
//   the result is valid in the cycle after input acceptance, and one byte
//   is taken every cycle while the receiver keeps up: the frame state
//   machine and its checks sit between the input and a single result register.
//   when the receiver stalls, the result register holds its item and
//   s_axis_tready drops in the same cycle; it rises again as soon as the
//   held item is taken.
//   reset puts the block into header hunt with cleared captured fields
//   and restores the register defaults (header 0xaa, footer 0x55, 57).
module packet_deframer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pdc_pkg::ByteW-1:0]     s_axis_tdata,  // [7:0] rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] payload_byte, [15:8] dest, [23:16] packet_type, [29:24] length,
  // [32:30] error_code, [39:33] zero
  output logic [pdc_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [pdc_pkg::EventW-1:0]    m_axis_tuser,  // [1:0] event_res
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdc_pkg::AddrW-1:0]     paddr,
  input  logic [pdc_pkg::DataW-1:0]     pwdata,
  output logic [pdc_pkg::DataW-1:0]     prdata,
  output logic                          pready
);
  import pdc_pkg::*;

  cfg_t    cfg;
  result_t res;

  pdc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pdc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tuser = res.event_res;
  assign m_axis_tdata = {7'd0, res.error_code, res.length, res.packet_type,
                         res.dest, res.payload_byte};

endmodule
